>>> rtl/trb_pkg.sv
// Shared types and constants of the TCP control reply builder.
// Holds the item structs, register indexes, opcodes and header constants.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package trb_pkg;

	// Header geometry: twenty 16-bit words, IPv4 header first.
	localparam int HDR_WORDS  = 20;
	localparam int WORD_IDX_W = $clog2(HDR_WORDS);

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_HOP_LIMIT   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'd1;

	// Register reset values.
	localparam logic [7:0]  HOP_LIMIT_RST   = 8'd128;
	localparam logic [15:0] WINDOW_SIZE_RST = 16'd256;

	// Reply kinds. The unused code is handled as a SYN-ACK.
	localparam logic [1:0] OP_SYN_ACK = 2'd0;
	localparam logic [1:0] OP_RST     = 2'd1;
	localparam logic [1:0] OP_ACK     = 2'd2;

	// TCP flag patterns.
	localparam logic [5:0] FLAGS_SYN_ACK = 6'h12;
	localparam logic [5:0] FLAGS_RST     = 6'h04;
	localparam logic [5:0] FLAGS_ACK     = 6'h10;

	// Fixed header fields.
	localparam logic [15:0] IP_VER_IHL   = 16'h4500;
	localparam logic [15:0] IP_TOTAL_LEN = 16'd40;
	localparam logic [15:0] IP_IDENT     = 16'h0000;
	localparam logic [15:0] IP_FLAGS_DF  = 16'h4000;
	localparam logic [7:0]  IP_PROTO_TCP = 8'd6;
	localparam logic [15:0] TCP_HDR_LEN  = 16'd20;
	localparam logic [15:0] TCP_DOFF     = 16'h5000;
	localparam logic [15:0] TCP_URG_PTR  = 16'h0000;

	// Sum of the constant IPv4 header words (TTL byte excluded).
	localparam logic [18:0] IP_FIXED_SUM = {3'b0, IP_VER_IHL} + {3'b0, IP_TOTAL_LEN}
		+ {3'b0, IP_IDENT} + {3'b0, IP_FLAGS_DF} + {11'b0, IP_PROTO_TCP};

	// Constant part of the TCP pseudoheader: protocol and segment length.
	localparam logic [19:0] TCP_PSEUDO_SUM = {12'b0, IP_PROTO_TCP} + {4'b0, TCP_HDR_LEN};

	// Request word as received.
	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] in_src_addr;
		logic [31:0] in_dst_addr;
		logic [15:0] in_src_port;
		logic [15:0] in_dst_port;
		logic [31:0] in_seq;
	} trb_req_t;

	// One output word of the reply header.
	typedef struct packed {
		logic [15:0] hdr_word;
		logic        last_word;
	} trb_word_t;

	// Reply header fields as built by the arithmetic pipeline.
	typedef struct packed {
		logic [31:0] src_addr;
		logic [31:0] peer_addr;
		logic [15:0] src_port;
		logic [15:0] peer_port;
		logic [31:0] seq_num;
		logic [31:0] ack_num;
		logic [5:0]  flags;
		logic [7:0]  ttl;
		logic [15:0] window;
		logic [15:0] ip_csum;
		logic [15:0] tcp_csum;
	} trb_hdr_t;

endpackage

>>> rtl/tcp_control_reply_builder_core.sv
// Top level of the TCP control reply builder: configuration registers and the two units.
// Depends on trb_pkg, trb_calc and trb_ser.
`timescale 1ns / 1ps

// Usage:
// A request word (reply kind, addresses, ports and sequence number of a received
// IPv4/TCP segment) enters on in_item with in_valid/in_ready. The reply header
// leaves on out_item as twenty 16-bit words in network order, IPv4 header first,
// last_word marking the twentieth; out_valid/out_ready move one word per cycle while
// out_ready is high. Four arithmetic stages compute the fields and both checksums,
// then the header loads into a shift line. The next header loads on the cycle its
// predecessor's last word is taken, giving gap-free output when a header is waiting.
// The pipeline keeps accepting requests until its four stages are full behind a
// stalled output; a stall loses and repeats nothing.
// Registers are written through cfg_we/cfg_idx/cfg_wdata; the user must write them
// only while the block is idle, which the block itself does not enforce:
// index 0 hop limit (TTL), index 1 window size.
// Reset clears all valid bits and sets TTL 128 and window 256.

module tcp_control_reply_builder_core
	import trb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  trb_req_t              in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output trb_word_t             out_item,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic [7:0]  hop_limit_q;
	logic [15:0] window_size_q;
	trb_hdr_t    hdr;
	logic        hdr_valid;
	logic        hdr_ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hop_limit_q   <= HOP_LIMIT_RST;
			window_size_q <= WINDOW_SIZE_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_HOP_LIMIT:   hop_limit_q   <= cfg_wdata[7:0];
				REG_WINDOW_SIZE: window_size_q <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// Field and checksum pipeline.
	trb_calc u_calc (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_item     (in_item),
		.hop_limit   (hop_limit_q),
		.window_size (window_size_q),
		.hdr         (hdr),
		.hdr_valid   (hdr_valid),
		.hdr_ready   (hdr_ready)
	);

	// Word serializer.
	trb_ser u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.hdr       (hdr),
		.hdr_valid (hdr_valid),
		.hdr_ready (hdr_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

>>> rtl/trb_calc.sv
// Four-stage arithmetic pipeline of the reply builder: header fields and both checksums.
// Depends on trb_pkg.
`timescale 1ns / 1ps

module trb_calc
	import trb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  trb_req_t   in_item,
	input  logic [7:0] hop_limit,
	input  logic [15:0] window_size,
	output trb_hdr_t   hdr,
	output logic       hdr_valid,
	input  logic       hdr_ready
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	trb_hdr_t hdr_s1, hdr_s2, hdr_s3, hdr_s4;
	logic [17:0] addr_sum_s1, addr_sum_s2;
	logic [18:0] ip_sum_s2;
	logic [18:0] tcp_part_s2;
	logic [16:0] ip_fold_s3;
	logic [19:0] tcp_sum_s3;

	trb_hdr_t    hdr_d1;
	logic [17:0] addr_sum_d1;
	logic [15:0] ip_fold_d4;
	logic [16:0] tcp_fold1_d4;
	logic [15:0] tcp_fold2_d4;
	trb_hdr_t    hdr_d4;

	// A stage takes a new word when it is empty or its word moves on.
	assign rdy_s4 = !v_s4 || hdr_ready;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	assign hdr_valid = v_s4;
	assign hdr = hdr_s4;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	// Stage 1 logic: swap the endpoints, pick flags, sequence and acknowledgement.
	always_comb begin
		hdr_d1 = '0;
		hdr_d1.src_addr  = in_item.in_dst_addr;
		hdr_d1.peer_addr = in_item.in_src_addr;
		hdr_d1.src_port  = in_item.in_dst_port;
		hdr_d1.peer_port = in_item.in_src_port;
		hdr_d1.ttl       = hop_limit;
		hdr_d1.window    = window_size;
		unique case (in_item.opcode)
			OP_RST: begin
				hdr_d1.flags   = FLAGS_RST;
				hdr_d1.seq_num = '0;
				hdr_d1.ack_num = '0;
			end
			OP_ACK: begin
				hdr_d1.flags   = FLAGS_ACK;
				hdr_d1.seq_num = '0;
				hdr_d1.ack_num = in_item.in_seq + 32'd1;
			end
			default: begin
				hdr_d1.flags   = FLAGS_SYN_ACK;
				hdr_d1.seq_num = in_item.in_seq;
				hdr_d1.ack_num = in_item.in_seq + 32'd1;
			end
		endcase
		// The four address words appear in both checksums.
		addr_sum_d1 = {2'b0, in_item.in_src_addr[31:16]} + {2'b0, in_item.in_src_addr[15:0]}
			+ {2'b0, in_item.in_dst_addr[31:16]} + {2'b0, in_item.in_dst_addr[15:0]};
	end

	// Stage 1 registers.
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			hdr_s1      <= hdr_d1;
			addr_sum_s1 <= addr_sum_d1;
		end
	end

	// Stage 2: IPv4 header sum and the TCP header words apart from the addresses.
	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			hdr_s2      <= hdr_s1;
			addr_sum_s2 <= addr_sum_s1;
			ip_sum_s2   <= {1'b0, addr_sum_s1} + IP_FIXED_SUM + {3'b0, hdr_s1.ttl, 8'h00};
			tcp_part_s2 <= {3'b0, hdr_s1.src_port} + {3'b0, hdr_s1.peer_port}
				+ {3'b0, hdr_s1.seq_num[31:16]} + {3'b0, hdr_s1.seq_num[15:0]}
				+ {3'b0, hdr_s1.ack_num[31:16]} + {3'b0, hdr_s1.ack_num[15:0]}
				+ {3'b0, TCP_DOFF | {10'b0, hdr_s1.flags}} + {3'b0, hdr_s1.window};
		end
	end

	// Stage 3: first fold of the IPv4 sum, full TCP sum with the pseudoheader.
	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			hdr_s3     <= hdr_s2;
			ip_fold_s3 <= {1'b0, ip_sum_s2[15:0]} + {14'b0, ip_sum_s2[18:16]};
			tcp_sum_s3 <= {1'b0, tcp_part_s2} + {2'b0, addr_sum_s2} + TCP_PSEUDO_SUM;
		end
	end

	// Stage 4 logic: final end-around carries and complement.
	always_comb begin
		ip_fold_d4   = ip_fold_s3[15:0] + {15'b0, ip_fold_s3[16]};
		tcp_fold1_d4 = {1'b0, tcp_sum_s3[15:0]} + {13'b0, tcp_sum_s3[19:16]};
		tcp_fold2_d4 = tcp_fold1_d4[15:0] + {15'b0, tcp_fold1_d4[16]};
		hdr_d4          = hdr_s3;
		hdr_d4.ip_csum  = ~ip_fold_d4;
		hdr_d4.tcp_csum = ~tcp_fold2_d4;
	end

	// Stage 4 registers.
	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			hdr_s4 <= hdr_d4;
		end
	end

`ifndef SYNTHESIS
	// A stalled header at the last stage is held intact.
	a_s4_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !hdr_ready) |=> (v_s4 && $stable(hdr_s4)))
		else $error("stalled header changed in last stage");

	// An accepted request occupies the first stage.
	a_s1_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> v_s1)
		else $error("accepted request lost at stage one");
`endif

endmodule

>>> rtl/trb_ser.sv
// Serializer of the reply builder: loads a finished header and sends twenty words.
// Depends on trb_pkg.
`timescale 1ns / 1ps

module trb_ser
	import trb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  trb_hdr_t  hdr,
	input  logic      hdr_valid,
	output logic      hdr_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output trb_word_t out_item
);

	localparam logic [WORD_IDX_W-1:0] LAST_IDX = WORD_IDX_W'(HDR_WORDS - 1);

	logic                  busy_q;
	logic [WORD_IDX_W-1:0] cnt_q;
	logic [15:0]           words_q [HDR_WORDS];
	logic [15:0]           words_d [HDR_WORDS];
	logic                  out_fire;
	logic                  is_last;
	logic                  load;

	assign is_last  = (cnt_q == LAST_IDX);
	assign out_fire = out_valid && out_ready;

	// A new header loads when the shift line is empty or its final word leaves.
	assign hdr_ready = !busy_q || (out_fire && is_last);
	assign load = hdr_valid && hdr_ready;

	assign out_valid          = busy_q;
	assign out_item.hdr_word  = words_q[0];
	assign out_item.last_word = is_last;

	// Header word layout in network order.
	always_comb begin
		words_d[0]  = IP_VER_IHL;
		words_d[1]  = IP_TOTAL_LEN;
		words_d[2]  = IP_IDENT;
		words_d[3]  = IP_FLAGS_DF;
		words_d[4]  = {hdr.ttl, IP_PROTO_TCP};
		words_d[5]  = hdr.ip_csum;
		words_d[6]  = hdr.src_addr[31:16];
		words_d[7]  = hdr.src_addr[15:0];
		words_d[8]  = hdr.peer_addr[31:16];
		words_d[9]  = hdr.peer_addr[15:0];
		words_d[10] = hdr.src_port;
		words_d[11] = hdr.peer_port;
		words_d[12] = hdr.seq_num[31:16];
		words_d[13] = hdr.seq_num[15:0];
		words_d[14] = hdr.ack_num[31:16];
		words_d[15] = hdr.ack_num[15:0];
		words_d[16] = TCP_DOFF | {10'b0, hdr.flags};
		words_d[17] = hdr.window;
		words_d[18] = hdr.tcp_csum;
		words_d[19] = TCP_URG_PTR;
	end

	// Control: busy flag and word counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (out_fire) begin
			if (is_last) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + WORD_IDX_W'(1);
		end
	end

	// Shift line: the head word is on the output, the rest move up when it is taken.
	always_ff @(posedge clk) begin
		if (load) begin
			words_q <= words_d;
		end else if (out_fire) begin
			for (int i = 0; i < HDR_WORDS - 1; i++) begin
				words_q[i] <= words_q[i + 1];
			end
		end
	end

`ifndef SYNTHESIS
	// A freshly loaded header starts with the version word.
	a_first_word: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (out_valid && out_item.hdr_word == IP_VER_IHL && !out_item.last_word))
		else $error("header does not start with the version word");

	// After the final word the output goes quiet unless a header was loaded.
	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && is_last && !hdr_valid) |=> !out_valid)
		else $error("words sent beyond the end of the header");

	// Within a header every taken word is followed by another.
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && !is_last) |=> out_valid)
		else $error("header cut short");
`endif

endmodule
